// ----- sv/i2ctprf_pkg.sv -----
// Shared types, codes and defaults for the I2C target pointer register file.
`timescale 1ns / 1ps

package i2ctprf_pkg;

    localparam int STORE_DEPTH_DEF = 256;

    // Request kinds
    localparam logic [1:0] REQ_BUS = 2'd0;
    localparam logic [1:0] REQ_LWR = 2'd1;
    localparam logic [1:0] REQ_LRD = 2'd2;

    // Controller status codes
    localparam logic [7:0] ST_ADDR_W      = 8'h60;
    localparam logic [7:0] ST_DATA_RX     = 8'h80;
    localparam logic [7:0] ST_ADDR_R      = 8'hA8;
    localparam logic [7:0] ST_DATA_TX_ACK = 8'hB8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [7:0] local_address;
    } in_word_t;

    typedef struct packed {
        logic       ack_enable;
        logic [7:0] tx_data;
        logic       tx_loaded;
        logic [7:0] local_read_data;
    } out_word_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic exec;
    } ctl_cmd_t;

endpackage

// ----- sv/i2c_target_pointer_register_file_core.sv -----
// Top level of the I2C target pointer register file.
//
// Byte-level side of an I2C target holding a byte store with an
// auto-incrementing pointer. The s_ channel takes one request word: a bus
// status event (status code plus received byte), or a local host write or
// read at local_address. The m_ channel returns one result word per
// request: ack flag, transmit byte with its load flag, and local read byte.
// Each request passes through accept, a registered store read, and an
// execute step that updates pointer, ack flag and store and loads the
// registered output; m_valid rises once that output is loaded. A new
// request is taken only after the previous one has executed, since s_ready
// is low in the read and execute steps. s_ready returns while a result
// still waits in the output register; if m_ready stays low, the next
// request parks in its execute cycle until the output register is taken.
// Reset (aresetn low, synchronous) clears the pointer and pointer flag, sets
// ACK, and marks every store entry as zero through per-entry valid bits, so
// the block takes requests right after reset.
`timescale 1ns / 1ps

module i2c_target_pointer_register_file_core
    import i2ctprf_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    ctl_cmd_t cmd;

    i2ctprf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    i2ctprf_dp #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .m_word  (m_word)
    );

    a_accept_then_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> cmd.rd_en)
        else $error("accepted word not followed by store read");

    a_busy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> !s_ready)
        else $error("input taken while a word is in execution");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("execute cycle did not present a result");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.rd_en, cmd.exec}))
        else $error("overlapping sequencer commands");

endmodule

// ----- sv/i2ctprf_store.sv -----
// Byte store with registered read and per-entry valid bits cleared at reset.
`timescale 1ns / 1ps

module i2ctprf_store
    import i2ctprf_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [7:0]             mem_q_reg;
    logic                   vld_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset value
    assign rd_data = vld_q_reg ? mem_q_reg : 8'd0;

endmodule

// ----- sv/i2ctprf_ctrl.sv -----
// Sequencer: accept, store read, execute and result hand-off.
`timescale 1ns / 1ps

module i2ctprf_ctrl
    import i2ctprf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ctl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        out_vld_next = out_vld_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // wait until the output register is free
                if (!out_vld_reg || m_ready) begin
                    cmd.exec     = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_valid = out_vld_reg;

endmodule

// ----- sv/i2ctprf_dp.sv -----
// Datapath: captured word, pointer/ack state, store access and result register.
`timescale 1ns / 1ps

module i2ctprf_dp
    import i2ctprf_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ctl_cmd_t  cmd,
    input  in_word_t  s_word,
    output out_word_t m_word
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = $clog2(STORE_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(STORE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(STORE_DEPTH - 1);
    localparam logic [8:0]    DEPTH9  = 9'(STORE_DEPTH);

    in_word_t      in_reg;
    out_word_t     out_reg;
    out_word_t     res;
    logic [PW-1:0] ptr_reg, ptr_next, ptr_inc;
    logic          have_reg, have_next;
    logic          ack_reg, ack_next;
    logic          ptr_lt, data_lt, addr_lt;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    i2ctprf_store #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_reg.data_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ptr_lt  = ptr_reg < DEPTH_P;
    assign data_lt = {1'b0, in_reg.data_byte} < DEPTH9;
    assign addr_lt = {1'b0, in_reg.local_address} < DEPTH9;
    assign ptr_inc = ptr_lt ? ptr_reg + PW'(1) : DEPTH_P;

    assign rd_addr = (in_reg.req_type == REQ_BUS) ? ptr_reg[AW-1:0]
                                                  : in_reg.local_address[AW-1:0];

    always_comb begin
        ptr_next  = ptr_reg;
        have_next = have_reg;
        ack_next  = ack_reg;
        wr_en     = 1'b0;
        wr_addr   = ptr_reg[AW-1:0];
        res       = '0;
        case (in_reg.req_type)
            REQ_BUS: begin
                case (in_reg.status_code)
                    ST_ADDR_W: begin
                        have_next = 1'b0;
                        ack_next  = 1'b1;
                    end
                    ST_DATA_RX: begin
                        if (!have_reg) begin
                            // first byte after addressing is the pointer
                            ptr_next  = data_lt ? PW'(in_reg.data_byte) : DEPTH_P;
                            have_next = 1'b1;
                        end else if (ptr_lt) begin
                            wr_en    = cmd.exec;
                            ptr_next = ptr_inc;
                            ack_next = 1'b1;
                        end else begin
                            ack_next = 1'b0;
                        end
                    end
                    ST_ADDR_R: begin
                        if (ptr_lt) begin
                            res.tx_data   = rd_data;
                            res.tx_loaded = 1'b1;
                            ptr_next      = ptr_inc;
                            ack_next      = 1'b1;
                        end
                        if (ptr_next == LAST_P) begin
                            ack_next = 1'b0;
                        end
                    end
                    ST_DATA_TX_ACK: begin
                        if (ptr_lt) begin
                            res.tx_data   = rd_data;
                            res.tx_loaded = 1'b1;
                        end
                        ptr_next = ptr_inc;
                        ack_next = (ptr_inc != LAST_P);
                    end
                    default: begin
                        ack_next = 1'b1;
                    end
                endcase
            end
            REQ_LWR: begin
                if (addr_lt) begin
                    wr_en   = cmd.exec;
                    wr_addr = in_reg.local_address[AW-1:0];
                end
            end
            REQ_LRD: begin
                if (addr_lt) begin
                    res.local_read_data = rd_data;
                end
            end
            default: begin
            end
        endcase
        res.ack_enable = ack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            have_reg <= 1'b0;
            ack_reg  <= 1'b1;
        end else if (cmd.exec) begin
            ptr_reg  <= ptr_next;
            have_reg <= have_next;
            ack_reg  <= ack_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_word;
        end
        if (cmd.exec) begin
            out_reg <= res;
        end
    end

    assign m_word = out_reg;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the I2C target pointer register file core.
`timescale 1ns / 1ps

module tb;
    import i2ctprf_pkg::*;

    localparam int DEPTH = STORE_DEPTH_DEF;
    localparam logic [8:0] PTR_END = 9'(DEPTH);
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [7:0] ST_OTHER = 8'h00;
    localparam int RAND_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN = 10;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} rx_mode_e;

    typedef struct {
        in_word_t  req;
        bit        fixed;
        out_word_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    i2c_target_pointer_register_file_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // mirror of the target state
    logic [7:0] shadow_mem [DEPTH];
    logic [8:0] shadow_ptr;
    bit         shadow_ptr_set;
    bit         shadow_ack;

    out_word_t reply_q [$];
    dir_row_t  dir_tab [$];

    int cycle_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int err_cnt = 0;
    int nack_cnt = 0;
    int load_cnt = 0;
    int burst_left = 0;
    int rx_phase_left = 0;
    int rx_tick = 0;
    rx_mode_e rx_mode = RX_OPEN;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [8:0] bump_ptr(input logic [8:0] p);
        return (p < PTR_END) ? p + 9'd1 : PTR_END;
    endfunction

    // next reply of the target; updates the mirrored state
    function automatic out_word_t target_reply(input in_word_t w);
        out_word_t r;
        r = '0;
        case (w.req_type)
            REQ_BUS: begin
                case (w.status_code)
                    ST_ADDR_W: begin
                        shadow_ptr_set = 1'b0;
                        shadow_ack = 1'b1;
                    end
                    ST_DATA_RX: begin
                        if (!shadow_ptr_set) begin
                            shadow_ptr = (w.data_byte < DEPTH) ? {1'b0, w.data_byte} : PTR_END;
                            shadow_ptr_set = 1'b1;
                        end else if (shadow_ptr < PTR_END) begin
                            shadow_mem[shadow_ptr[7:0]] = w.data_byte;
                            shadow_ptr = bump_ptr(shadow_ptr);
                            shadow_ack = 1'b1;
                        end else begin
                            shadow_ack = 1'b0;
                        end
                    end
                    ST_ADDR_R: begin
                        if (shadow_ptr < PTR_END) begin
                            r.tx_data = shadow_mem[shadow_ptr[7:0]];
                            r.tx_loaded = 1'b1;
                            shadow_ptr = bump_ptr(shadow_ptr);
                            shadow_ack = 1'b1;
                        end
                        if (shadow_ptr == PTR_END - 9'd1)
                            shadow_ack = 1'b0;
                    end
                    ST_DATA_TX_ACK: begin
                        if (shadow_ptr < PTR_END) begin
                            r.tx_data = shadow_mem[shadow_ptr[7:0]];
                            r.tx_loaded = 1'b1;
                        end
                        shadow_ptr = bump_ptr(shadow_ptr);
                        shadow_ack = (shadow_ptr != PTR_END - 9'd1);
                    end
                    default: shadow_ack = 1'b1;
                endcase
            end
            REQ_LWR: begin
                if (w.local_address < DEPTH)
                    shadow_mem[w.local_address] = w.data_byte;
            end
            REQ_LRD: begin
                if (w.local_address < DEPTH)
                    r.local_read_data = shadow_mem[w.local_address];
            end
            default: ;
        endcase
        r.ack_enable = shadow_ack;
        return r;
    endfunction

    function automatic in_word_t mk_word(input logic [1:0] req, input logic [7:0] code,
                                         input logic [7:0] data, input logic [7:0] addr);
        in_word_t w;
        w.req_type = req;
        w.status_code = code;
        w.data_byte = data;
        w.local_address = addr;
        return w;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] req, input logic [7:0] code,
                                        input logic [7:0] data, input logic [7:0] addr,
                                        input bit fixed, input logic ack,
                                        input logic [7:0] tx, input logic loaded,
                                        input logic [7:0] lrd);
        dir_row_t d;
        d.req = mk_word(req, code, data, addr);
        d.fixed = fixed;
        d.want.ack_enable = ack;
        d.want.tx_data = tx;
        d.want.tx_loaded = loaded;
        d.want.local_read_data = lrd;
        return d;
    endfunction

    // bus event with a random, unused local address
    function automatic in_word_t bus_word(input logic [7:0] code, input logic [7:0] data);
        return mk_word(REQ_BUS, code, data, 8'($urandom_range(0, 255)));
    endfunction

    // present one word in the current burst; returns at the falling edge after acceptance
    task automatic issue(input in_word_t w, input bit fixed, input out_word_t want);
        out_word_t pred;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = target_reply(w);
        reply_q.push_back(fixed ? want : pred);
        sent_cnt++;
        @(negedge aclk);
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(50, 300);
        end
        rx_phase_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            RX_SLOW: m_ready <= ($urandom_range(0, 3) == 0);
            RX_BEAT: m_ready <= ((rx_tick % 5) < 2);
            default: m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        out_word_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt, reply_q.size());
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (reply_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("%0t: unexpected result word %h", $realtime, m_word);
            end else begin
                want = reply_q.pop_front();
                checked_cnt++;
                if (m_word.ack_enable !== want.ack_enable || m_word.tx_data !== want.tx_data ||
                    m_word.tx_loaded !== want.tx_loaded ||
                    m_word.local_read_data !== want.local_read_data) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display("%0t: result %0d ack %b/%b tx %h/%h loaded %b/%b lrd %h/%h (exp/act)",
                                 $realtime, checked_cnt, want.ack_enable, m_word.ack_enable,
                                 want.tx_data, m_word.tx_data, want.tx_loaded, m_word.tx_loaded,
                                 want.local_read_data, m_word.local_read_data);
                end
                if (!want.ack_enable) nack_cnt++;
                if (want.tx_loaded) load_cnt++;
            end
        end
    end

    initial begin
        int n_dir;
        int n;
        int pick;
        logic [7:0] ptr_byte;
        out_word_t none;

        none = '0;
        foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
        shadow_ptr = 9'd0;
        shadow_ptr_set = 1'b0;
        shadow_ack = 1'b1;

        // after reset, extremes of the store, ignored request
        dir_tab.push_back(mk_row(REQ_LRD, 8'h00, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_LRD, 8'hFF, 8'hFF, 8'hFF, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_LWR, 8'h00, 8'hFF, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_LWR, 8'hFF, 8'hA5, 8'hFF, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_LRD, 8'h00, 8'h00, 8'hFF, 1, 1'b1, 8'h00, 1'b0, 8'hA5));
        // bus write running off the end of the store
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_W, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'hFE, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'h11, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'h22, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'h33, 8'h00, 1, 1'b0, 8'h00, 1'b0, 8'h00));
        // reads with the pointer parked at the end load nothing
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_R, 8'h00, 8'h00, 1, 1'b0, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_TX_ACK, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0,
                                 8'h00));
        // read across the last entry
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_W, 8'hFF, 8'hFF, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'hFD, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_R, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_TX_ACK, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_TX_ACK, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_TX_ACK, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_OTHER, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        // read from entry zero
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_W, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_R, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b0, 8'h00));
        // address-read of the next to last entry moves the pointer to the last entry and gives NACK
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_W, 8'h00, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_DATA_RX, 8'hFE, 8'h00, 1, 1'b1, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(REQ_BUS, ST_ADDR_R, 8'h00, 8'h00, 0, 1'b0, 8'h00, 1'b0, 8'h00));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);
        n_dir = sent_cnt;

        while (sent_cnt < n_dir + RAND_ITEMS) begin
            // now and then hold off until the target has answered everything
            if (sent_cnt == n_dir || $urandom_range(0, 39) == 0) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (reply_q.size() != 0);
                burst_left = $urandom_range(1, 12);
            end
            pick = $urandom_range(0, 99);
            ptr_byte = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(240, 255))
                                                   : 8'($urandom_range(0, 255));
            n = $urandom_range(0, 12);
            if (pick < 40) begin
                // bus write: address, pointer, data bytes
                issue(bus_word(ST_ADDR_W, 8'($urandom_range(0, 255))), 0, none);
                issue(bus_word(ST_DATA_RX, ptr_byte), 0, none);
                repeat (n) issue(bus_word(ST_DATA_RX, 8'($urandom_range(0, 255))), 0, none);
            end else if (pick < 75) begin
                // bus read, mostly after a pointer write
                if ($urandom_range(0, 4) != 0) begin
                    issue(bus_word(ST_ADDR_W, 8'($urandom_range(0, 255))), 0, none);
                    issue(bus_word(ST_DATA_RX, ptr_byte), 0, none);
                end
                issue(bus_word(ST_ADDR_R, 8'($urandom_range(0, 255))), 0, none);
                repeat (n) issue(bus_word(ST_DATA_TX_ACK, 8'($urandom_range(0, 255))), 0, none);
            end else if (pick < 90) begin
                repeat (n + 1)
                    issue(mk_word(($urandom_range(0, 1) == 1) ? REQ_LWR : REQ_LRD,
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255))), 0, none);
            end else begin
                // noise: any request kind, any code
                repeat (n + 1)
                    issue(mk_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
                          0, none);
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (reply_q.size() != 0);
        repeat (8) @(negedge aclk);

        $display("%0d requests sent (%0d directed), %0d results checked, %0d mismatches",
                 sent_cnt, n_dir, checked_cnt, err_cnt);
        $display("results with NACK: %0d, with a bus byte loaded: %0d", nack_cnt, load_cnt);
        if (err_cnt == 0 && reply_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
